// ===== design/sbsh_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// Used by sbsh_round_unit and sha256_byte_stream_hasher; no dependencies.
package sbsh_pkg;

  localparam int WORD_W  = 32;
  localparam int HASH_N  = 8;
  localparam int BLOCK_N = 16;
  localparam int ROUND_N = 64;
  localparam int FILL_W  = 6;
  // message bit count is kept mod 2^64, so byte count needs only 61 bits
  localparam int TOTAL_W = 61;
  localparam int LEN_POS = 56;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef logic [HASH_N-1:0][WORD_W-1:0]  hash_t;
  typedef logic [BLOCK_N-1:0][WORD_W-1:0] sched_t;

  typedef struct packed {
    logic start;
    logic init;
    logic push;
  } core_ctrl_t;

  localparam logic [WORD_W-1:0] IV_TABLE [HASH_N] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] K_TABLE [ROUND_N] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== design/sbsh_round_unit.sv =====
// SHA-256 compression unit: one round per cycle, rolling 16-word schedule window.
// Holds the chaining hash, the round variables and the block buffer. Uses sbsh_pkg.
module sbsh_round_unit import sbsh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  core_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] push_word,
  output logic              done,
  output hash_t             hash
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD} core_state_t;

  core_state_t       st_r;
  logic [5:0]        rnd_r;
  hash_t             h_r;
  hash_t             v_r;
  hash_t             v_nxt;
  sched_t            w_r;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] w_new;

  always_comb begin
    t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + K_TABLE[rnd_r] + w_r[0];
    t2 = big_sigma0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
    // w[i+16] from the window w[i..i+15]
    w_new = w_r[0] + small_sigma0(w_r[1]) + w_r[9] + small_sigma1(w_r[14]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      rnd_r <= '0;
      for (int i = 0; i < HASH_N; i++) h_r[i] <= IV_TABLE[i];
    end else begin
      unique case (st_r)
        C_IDLE: begin
          if (ctrl.start) begin
            v_r   <= h_r;
            rnd_r <= '0;
            st_r  <= C_RUN;
          end
        end
        C_RUN: begin
          v_r   <= v_nxt;
          w_r   <= {w_new, w_r[BLOCK_N-1:1]};
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(ROUND_N - 1)) st_r <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < HASH_N; i++) h_r[i] <= h_r[i] + v_r[i];
          st_r <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
      if (ctrl.push) w_r <= {push_word, w_r[BLOCK_N-1:1]};
      if (ctrl.init) begin
        for (int i = 0; i < HASH_N; i++) h_r[i] <= IV_TABLE[i];
      end
    end
  end

  assign done = (st_r == C_ADD);
  assign hash = h_r;

`ifndef SYNTHESIS
  a_ctrl_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.push || ctrl.start || ctrl.init) |-> st_r == C_IDLE)
    else $error("buffer or hash touched while compression runs");

  a_done_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ($past(st_r) == C_RUN && $past(rnd_r) == 6'(ROUND_N - 1)))
    else $error("hash update without a full set of rounds");
`endif

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream; top level with byte packing, padding and digest output.
// A beat that completes a 64-byte block stalls input through the rounds and the add.
// End of message: up to 72 padding bytes, one per cycle outside compressions; one or
// two compressions, then eight digest beats; the single round unit sets throughput.
// Reset (synchronous, rst_n low): initial hash values, empty buffer, zero byte count.
module sha256_byte_stream_hasher import sbsh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_end_of_message,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_PAD, S_OUT} top_state_t;

  top_state_t          state_r;
  logic [FILL_W-1:0]   fill_r;
  logic [TOTAL_W-1:0]  total_r;
  logic [23:0]         acc_r;
  logic                mark_r;
  logic                len_ok_r;
  logic                eom_pend_r;
  logic                final_r;
  logic [2:0]          idx_r;

  logic                accept_in;
  logic                pad_len;
  logic [7:0]          pad_byte;
  logic                push_en;
  logic [7:0]          push_byte;
  logic                core_done;
  core_ctrl_t          ctrl;
  hash_t               hash;

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    accept_in = in_valid && !in_stall;
    // length bytes only in the block that also holds (or follows) the marker
    pad_len   = mark_r && len_ok_r && (fill_r >= FILL_W'(LEN_POS));
    if (!mark_r) pad_byte = PAD_MARK;
    else if (pad_len) pad_byte = total_r[TOTAL_W-1 -: 8];
    else pad_byte = 8'h00;
    push_en    = (accept_in && in_has_byte) || (state_r == S_PAD);
    push_byte  = (state_r == S_PAD) ? pad_byte : in_data_byte;
    ctrl.push  = push_en && (fill_r[1:0] == 2'b11);
    ctrl.start = push_en && (fill_r == FILL_W'(BLOCK_N * 4 - 1));
    ctrl.init  = out_valid && !out_stall && out_last_word;
  end

  sbsh_round_unit u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .push_word ({acc_r, push_byte}),
    .done      (core_done),
    .hash      (hash)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      total_r    <= '0;
      mark_r     <= 1'b0;
      len_ok_r   <= 1'b0;
      eom_pend_r <= 1'b0;
      final_r    <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (push_en) begin
        acc_r  <= {acc_r[15:0], push_byte};
        fill_r <= fill_r + FILL_W'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            if (in_has_byte) total_r <= total_r + TOTAL_W'(1);
            if (ctrl.start) begin
              state_r    <= S_ROUND;
              eom_pend_r <= in_end_of_message;
              mark_r     <= 1'b0;
            end else if (in_end_of_message) begin
              state_r <= S_PAD;
              mark_r  <= 1'b0;
            end
          end
        end
        S_ROUND: begin
          if (core_done) begin
            if (final_r) state_r <= S_OUT;
            else if (eom_pend_r) state_r <= S_PAD;
            else state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          if (!mark_r) begin
            mark_r   <= 1'b1;
            len_ok_r <= (fill_r <= FILL_W'(LEN_POS - 1));
          end
          if (pad_len) total_r <= total_r << 8;
          if (ctrl.start) begin
            state_r    <= S_ROUND;
            final_r    <= mark_r && len_ok_r;
            eom_pend_r <= 1'b1;
            len_ok_r   <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (out_last_word) begin
              state_r    <= S_IDLE;
              total_r    <= '0;
              mark_r     <= 1'b0;
              len_ok_r   <= 1'b0;
              eom_pend_r <= 1'b0;
              final_r    <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = hash[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'(HASH_N - 1));

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input taken while digest beats are pending");

  a_clean_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word && !out_stall) |=>
      (fill_r == '0 && total_r == '0 && !out_valid && !mark_r))
    else $error("message state not cleared after last digest beat");

  a_done_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> state_r == S_ROUND)
    else $error("compression finished outside round wait");
`endif

endmodule

// ===== dv/sha256_byte_stream_hasher_tb.sv =====
// Self-checking testbench for sha256_byte_stream_hasher: drives byte beats and checks
// the digest words against a SHA-256 predictor held in a scoreboard class.
// Depends on sbsh_pkg (port widths) and the block's top level only.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BEATS = 420;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 300;

  localparam bit [7:0] PAD_BYTE = 8'h80;

  localparam bit [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        last;
  } digest_beat_t;

  class digest_tracker;
    bit [31:0]    chain [8];
    bit [7:0]     blk_bytes [64];
    int unsigned  fill;
    bit [63:0]    msg_bytes;
    digest_beat_t digests_due [$];
    int           mismatches;

    function void restart();
      foreach (chain[i]) chain[i] = INIT_HASH[i];
      foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
      fill = 0;
      msg_bytes = 64'd0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the buffered block; buffer is cleared after
    function void compress();
      bit [31:0] w [64];
      bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) +
               w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
             ROUND_K[i] + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
    endfunction

    // note an accepted input beat; an end-of-message beat queues eight digest words
    function void take_beat(bit [7:0] data, bit has, bit eom);
      bit [63:0] bit_len;
      if (has) begin
        blk_bytes[fill] = data;
        msg_bytes++;
        fill++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom)
        return;
      bit_len = msg_bytes << 3;
      blk_bytes[fill] = PAD_BYTE;
      // no room left for the length: it goes into an extra block
      if (fill > 55)
        compress();
      for (int k = 0; k < 8; k++)
        blk_bytes[56+k] = bit_len[63-8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++)
        digests_due.push_back('{word: chain[k], idx: 3'(k), last: (k == 7)});
      restart();
    endfunction

    function void check_word(bit [31:0] word, bit [2:0] idx, bit last);
      digest_beat_t exp_beat;
      if (digests_due.size() == 0) begin
        $display("%0t: unexpected digest beat: word %h index %0d last %0b",
                 $time, word, idx, last);
        mismatches++;
        return;
      end
      exp_beat = digests_due.pop_front();
      if (word !== exp_beat.word) begin
        $display("%0t: digest word: expected %h, got %h", $time, exp_beat.word, word);
        mismatches++;
      end
      if (idx !== exp_beat.idx) begin
        $display("%0t: word index: expected %0d, got %0d", $time, exp_beat.idx, idx);
        mismatches++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last word: expected %0b, got %0b", $time, exp_beat.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_data_byte;
  logic                          in_has_byte;
  logic                          in_end_of_message;
  logic                          out_valid;
  logic                          out_stall;
  logic [sbsh_pkg::WORD_W-1:0]   out_digest_word;
  logic [2:0]                    out_word_index;
  logic                          out_last_word;

  digest_tracker hasher = new;
  bit            in_idle_en;
  bit            out_idle_en;
  bit            hold_req;
  int unsigned   cycle_count;

  sha256_byte_stream_hasher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      hasher.check_word(out_digest_word, out_word_index, out_last_word);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic bit [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(input bit [7:0] data, input bit has, input bit eom);
    int gap;
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_has_byte       <= has;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall !== 1'b0);
    hasher.take_beat(data, has, eom);
  endtask

  initial begin
    int msg_beats;
    int len;
    bit end_with_byte;
    bit hold_done;
    cycle_count       = 0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'h00;
    in_has_byte       = 1'b0;
    in_end_of_message = 1'b0;
    in_idle_en        = 1'b1;
    out_idle_en       = 1'b1;
    hold_req          = 1'b0;
    hold_done         = 1'b0;
    msg_beats         = 0;
    hasher.restart();
    hasher.mismatches = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message, single bytes at the extremes, a short message,
    // end without a byte after bytes, no-op beats, back-to-back empty messages
    send_beat(8'h3c, 1'b0, 1'b1);
    send_beat(8'ha5, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b1);

    // random messages; lengths lean on the padding and block boundaries
    while (msg_beats < RANDOM_BEATS) begin
      in_idle_en  = (msg_beats < 150) || (msg_beats >= 230 && msg_beats < 330);
      out_idle_en = in_idle_en;
      if (!hold_done && msg_beats >= 230) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0:             len = 0;
        1, 2, 3, 4, 5: len = $urandom_range(1, 20);
        6:             len = $urandom_range(52, 66);
        7:             len = $urandom_range(115, 130);
        default:       len = $urandom_range(21, 51);
      endcase
      end_with_byte = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_beat(rand_byte(), 1'b1, end_with_byte && (i == len - 1));
        msg_beats++;
      end
      if (len == 0 || !end_with_byte) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        msg_beats++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (hasher.digests_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hasher.digests_due.size() != 0)
      $display("%0t: %0d digest words never arrived", $time, hasher.digests_due.size());
    if (hasher.mismatches == 0 && hasher.digests_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
